// ===== rtl/rgb2yuv_pkg.sv =====
// Shared types, constants and arithmetic of the RGB to YUV 4:2:0 converter.
package rgb2yuv_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CFG_W         = 13;
    localparam int TERM_W        = 16;
    localparam int PAIR_W        = TERM_W + 1;
    localparam int TOTAL_W       = PAIR_W + 1;
    localparam int ACC_W         = 18;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd1280;

    localparam logic [15:0] Y_R      = 16'd66;
    localparam logic [15:0] Y_G      = 16'd129;
    localparam logic [15:0] Y_B      = 16'd25;
    localparam logic [15:0] Y_ROUND  = 16'd128;
    localparam logic [7:0]  Y_OFFSET = 8'd16;

    localparam logic signed [ACC_W-1:0] U_R    = -18'sd38;
    localparam logic signed [ACC_W-1:0] U_G    = -18'sd74;
    localparam logic signed [ACC_W-1:0] U_B    = 18'sd112;
    localparam logic signed [ACC_W-1:0] V_R    = 18'sd112;
    localparam logic signed [ACC_W-1:0] V_G    = -18'sd94;
    localparam logic signed [ACC_W-1:0] V_B    = -18'sd18;
    localparam logic signed [ACC_W-1:0] C_BIAS = 18'sd128;

    localparam logic [TOTAL_W-1:0] C_OFFSET = 18'd512;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       row_end;
    } pixel_out_t;

    typedef struct packed {
        logic pair_end;
        logic odd_row;
        logic lookup;
        logic row_end;
    } col_ctrl_t;

    function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [15:0] acc;
        acc = Y_R * {8'd0, r} + Y_G * {8'd0, g} + Y_B * {8'd0, b} + Y_ROUND;
        return acc[15:8] + Y_OFFSET;
    endfunction

    function automatic logic signed [TERM_W-1:0] term_of(
        logic [7:0] r, logic [7:0] g, logic [7:0] b,
        logic signed [ACC_W-1:0] kr, logic signed [ACC_W-1:0] kg,
        logic signed [ACC_W-1:0] kb);
        logic signed [ACC_W-1:0] acc;
        acc = kr * $signed({10'd0, r}) + kg * $signed({10'd0, g})
            + kb * $signed({10'd0, b}) + C_BIAS;
        return $signed(acc[TERM_W-1:0]);
    endfunction

    function automatic logic [7:0] chroma_of(logic signed [TOTAL_W-1:0] total);
        logic [TOTAL_W-1:0] biased;
        biased = $unsigned(total >>> 8) + C_OFFSET;
        return biased[9:2];
    endfunction

endpackage

// ===== rtl/rgb2yuv_line_buf.sv =====
// Chroma line buffer: one write port, one read port with registered read data.
module rgb2yuv_line_buf #(
    parameter int SLOT_W = 11,
    parameter int DATA_W = 34
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 2 ** SLOT_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rgb2yuv_col_ctrl.sv =====
// Width register, column counter and row parity of the converter.
module rgb2yuv_col_ctrl #(
    parameter int MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = 12,
    parameter int SLOT_W    = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [rgb2yuv_pkg::CFG_W-1:0] cfg_data,
    input  logic                          advance,
    output rgb2yuv_pkg::col_ctrl_t        ctrl,
    output logic [SLOT_W-1:0]             slot
);

    import rgb2yuv_pkg::*;

    localparam int MAXW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W   = (MAXW_BITS > CFG_W) ? MAXW_BITS : CFG_W;

    logic [CFG_W-1:0]   width_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               odd_row_reg;
    logic               odd_row_next;
    logic [WIDTH_W-1:0] width_even;
    logic [WIDTH_W-1:0] width_clamp;
    logic               last;

    always_comb
    begin
        width_even = WIDTH_W'({width_reg[CFG_W-1:1], 1'b0});
        if (width_even < WIDTH_W'(2))
        begin
            width_clamp = WIDTH_W'(2);
        end
        else if (width_even > WIDTH_W'(MAX_WIDTH))
        begin
            width_clamp = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamp = width_even;
        end
        last = WIDTH_W'(col_reg) >= (width_clamp - WIDTH_W'(1));
    end

    always_comb
    begin
        col_next     = col_reg;
        odd_row_next = odd_row_reg;
        if (advance)
        begin
            if (last)
            begin
                col_next     = '0;
                odd_row_next = ~odd_row_reg;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            col_reg     <= '0;
            odd_row_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                width_reg <= cfg_data;
            end
            col_reg     <= col_next;
            odd_row_reg <= odd_row_next;
        end
    end

    assign ctrl.pair_end = col_reg[0];
    assign ctrl.odd_row  = odd_row_reg;
    assign ctrl.lookup   = col_reg[0] & odd_row_reg;
    assign ctrl.row_end  = last;
    assign slot          = col_reg[COL_W-1:1];

endmodule

// ===== rtl/rgb_to_yuv420_converter_core.sv =====
// Top level of the RGB to YUV 4:2:0 converter (BT.601 integer form).
//
// Input channel in_*: one RGB pixel per transfer, raster order. Output channel
// out_*: one result per pixel with luma, row_end and, on the second pixel of
// each odd-row pair, the U and V of the finished 2x2 block (zero otherwise).
// Config channel cfg_*: image width in pixels, even; always ready. Write it
// only while no pixel is in flight.
// An accepted pixel passes the stage 1, stage 2 and output registers to out_*.
// Throughput: one pixel per clock while in_ready is high; the line buffer has
// one read and one write port, written by even rows and read by odd rows.
// A stall of the receiver freezes the whole pipeline; in_ready drops only
// while a finished result waits in the output register and out_ready is low.
// Reset sets the width to 1280 and starts at column 0 of an even row; the
// line buffer is not cleared, the first row fills it before it is read.
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH = rgb2yuv_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rgb2yuv_pkg::CFG_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rgb2yuv_pkg::pixel_in_t        in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rgb2yuv_pkg::pixel_out_t       out_data
);

    import rgb2yuv_pkg::*;

    localparam int COL_LOG = $clog2(MAX_WIDTH);
    localparam int COL_W   = (COL_LOG < 2) ? 2 : COL_LOG;
    localparam int SLOT_W  = COL_W - 1;
    localparam int BUF_W   = 2 * PAIR_W;

    logic                     enable;
    logic                     accept;
    col_ctrl_t                ctrl;
    logic [SLOT_W-1:0]        slot;

    logic                     s1_valid_reg;
    pixel_in_t                s1_pix_reg;
    col_ctrl_t                s1_ctrl_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;

    logic signed [TERM_W-1:0] first_u_reg;
    logic signed [TERM_W-1:0] first_v_reg;
    logic [7:0]               s1_luma;
    logic signed [TERM_W-1:0] s1_uterm;
    logic signed [TERM_W-1:0] s1_vterm;
    logic signed [PAIR_W-1:0] s1_usum;
    logic signed [PAIR_W-1:0] s1_vsum;
    logic [BUF_W-1:0]         above;
    logic                     buf_wr;

    logic                     s2_valid_reg;
    col_ctrl_t                s2_ctrl_reg;
    logic [7:0]               s2_luma_reg;
    logic signed [PAIR_W-1:0] s2_usum_reg;
    logic signed [PAIR_W-1:0] s2_vsum_reg;
    logic [BUF_W-1:0]         s2_above_reg;
    logic signed [TOTAL_W-1:0] s2_utotal;
    logic signed [TOTAL_W-1:0] s2_vtotal;

    logic                     out_valid_reg;
    pixel_out_t               out_data_reg;
    pixel_out_t               out_data_next;

    assign enable    = !out_valid_reg || out_ready;
    assign in_ready  = enable;
    assign accept    = in_valid && enable;
    assign cfg_ready = 1'b1;

    rgb2yuv_col_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .SLOT_W    (SLOT_W)
    ) u_col_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid),
        .cfg_data (cfg_data),
        .advance  (accept),
        .ctrl     (ctrl),
        .slot     (slot)
    );

    rgb2yuv_line_buf #(
        .SLOT_W (SLOT_W),
        .DATA_W (BUF_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (buf_wr),
        .wr_addr (s1_slot_reg),
        .wr_data ({s1_usum, s1_vsum}),
        .rd_en   (accept && ctrl.lookup),
        .rd_addr (slot),
        .rd_data (above)
    );

    // Stage 1: color math and pair sums
    always_comb
    begin
        s1_luma  = luma_of(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue);
        s1_uterm = term_of(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue,
                           U_R, U_G, U_B);
        s1_vterm = term_of(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue,
                           V_R, V_G, V_B);
        s1_usum  = PAIR_W'(first_u_reg) + PAIR_W'(s1_uterm);
        s1_vsum  = PAIR_W'(first_v_reg) + PAIR_W'(s1_vterm);
        buf_wr   = enable && s1_valid_reg && s1_ctrl_reg.pair_end && !s1_ctrl_reg.odd_row;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= in_data;
            s1_ctrl_reg <= ctrl;
            s1_slot_reg <= slot;
        end
        if (enable && s1_valid_reg && !s1_ctrl_reg.pair_end)
        begin
            first_u_reg <= s1_uterm;
            first_v_reg <= s1_vterm;
        end
        if (enable && s1_valid_reg)
        begin
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_luma_reg  <= s1_luma;
            s2_usum_reg  <= s1_usum;
            s2_vsum_reg  <= s1_vsum;
            s2_above_reg <= above;
        end
        if (enable && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Stage 2: four-pixel totals and chroma
    always_comb
    begin
        s2_utotal = TOTAL_W'(s2_usum_reg) + TOTAL_W'($signed(s2_above_reg[BUF_W-1:PAIR_W]));
        s2_vtotal = TOTAL_W'(s2_vsum_reg) + TOTAL_W'($signed(s2_above_reg[PAIR_W-1:0]));
        out_data_next.luma         = s2_luma_reg;
        out_data_next.chroma_valid = s2_ctrl_reg.lookup;
        out_data_next.chroma_u     = s2_ctrl_reg.lookup ? chroma_of(s2_utotal) : 8'd0;
        out_data_next.chroma_v     = s2_ctrl_reg.lookup ? chroma_of(s2_vtotal) : 8'd0;
        out_data_next.row_end      = s2_ctrl_reg.row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
